// ----- hw/rtl/two_level_priority_event_fifo_assert.svh -----
// assertion macros for the two-level priority event fifo
// used by the queue and back-end modules; expects clock and reset in scope
`ifndef TWO_LEVEL_PRIORITY_EVENT_FIFO_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_EVENT_FIFO_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define TLPEF_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define TLPEF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tlpef_pkg.sv -----
// shared types, codes and defaults of the two-level priority event fifo
// no dependencies; imported by every module of the block
package tlpef_pkg;

   // default parameter values
   localparam int RING_DEPTH_DEF      = 16;
   localparam int HANDLE_BITS_DEF     = 16;
   localparam int PRIORITY_LEVELS_DEF = 8;
   localparam int QUEUE_DEPTH         = 2;

   // fixed field widths
   localparam int CMD_W      = 2;
   localparam int PRIO_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 32;
   localparam int TOTAL_W    = 6;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int OP_W       = 2;

   // command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

   // status codes on the response channel
   localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PRIORITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_LEVEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_CAP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_URGENT_CAP   = 2'd3;

   // classified operations handed from front to back
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
   localparam logic [OP_W-1:0] OP_NULL    = 2'd1;
   localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd2;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd3;

   typedef struct packed {
      logic              use_priority_path;
      logic [PRIO_W-1:0] critical_level;
      logic [CAP_W-1:0]  main_capacity;
      logic [CAP_W-1:0]  urgent_capacity;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      use_priority_path: 1'b0,
      critical_level:    3'd7,
      main_capacity:     5'd16,
      urgent_capacity:   5'd16
   };

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              to_urgent;
      logic [PRIO_W-1:0] prio;
   } cmd_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                from_urgent;
      logic [TOTAL_W-1:0]  total_count;
      logic                all_empty;
      logic                all_full;
      logic [COUNT_W-1:0]  dropped_count;
      logic [COUNT_W-1:0]  urgent_routed_count;
      logic [COUNT_W-1:0]  urgent_served_count;
      logic [COUNT_W-1:0]  level_count;
   } rsp_stat_type;

endpackage

// ----- hw/rtl/tlpef_queue.sv -----
// small register-based fifo used between the front, the back and the response port
// depends on tlpef_pkg and the assertion macro header
`include "two_level_priority_event_fifo_assert.svh"

module tlpef_queue import tlpef_pkg::*; #(
   parameter int  DEPTH     = QUEUE_DEPTH,
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type wdata,
   output logic     full,
   input  logic     pop,
   output data_type rdata,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // handshake qualification
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push_ok ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   `TLPEF_ASSERT_ALWAYS(a_queue_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `TLPEF_ASSERT_NEXT(a_queue_count_grows, push_ok && !pop_ok, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")

endmodule

// ----- hw/rtl/tlpef_front.sv -----
// front end: configuration registers and classification of incoming commands
// depends on tlpef_pkg
module tlpef_front import tlpef_pkg::*; #(
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [HANDLE_BITS-1:0] req_event_handle,
   input  logic [PRIO_W-1:0]     req_event_priority,
   output cfg_type               cfg,
   output cmd_ctrl_type          ctrl
);

   cfg_type cfg_ff, cfg_in;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USE_PRIORITY: cfg_in.use_priority_path = csr_write_data[0];
            CSR_CRIT_LEVEL:   cfg_in.critical_level    = csr_write_data[PRIO_W-1:0];
            CSR_MAIN_CAP:     cfg_in.main_capacity     = csr_write_data[CAP_W-1:0];
            CSR_URGENT_CAP:   cfg_in.urgent_capacity   = csr_write_data[CAP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // classify the transaction: null handle, ring choice, query
   always_comb begin
      ctrl.prio      = req_event_priority;
      ctrl.to_urgent = 1'b0;
      unique case (req_cmd)
         CMD_ENQUEUE: begin
            if (req_event_handle == '0) begin
               ctrl.op = OP_NULL;
            end else begin
               ctrl.op        = OP_ENQUEUE;
               ctrl.to_urgent = cfg_ff.use_priority_path &&
                                (req_event_priority == cfg_ff.critical_level);
            end
         end
         CMD_DEQUEUE: ctrl.op = OP_DEQUEUE;
         default:     ctrl.op = OP_QUERY;
      endcase
   end

endmodule

// ----- hw/rtl/tlpef_back.sv -----
// back end: both rings, their pointers and fills, statistics counters and result build
// depends on tlpef_pkg and the assertion macro header
`include "two_level_priority_event_fifo_assert.svh"

module tlpef_back import tlpef_pkg::*; #(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int HANDLE_BITS     = HANDLE_BITS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   cmd_valid,
   input  cmd_ctrl_type           cmd_ctrl,
   input  logic [HANDLE_BITS-1:0] cmd_handle,
   output logic                   cmd_take,
   input  logic                   rsp_room,
   output logic                   rsp_push,
   output rsp_stat_type           rsp_stat,
   output logic [HANDLE_BITS-1:0] rsp_handle
);

   localparam int PTR_W     = $clog2(RING_DEPTH);
   localparam int FILL_W    = $clog2(RING_DEPTH + 1);
   localparam int LVL_W     = $clog2(PRIORITY_LEVELS);
   localparam int LVL_EXT_W = LVL_W + PRIO_W;
   localparam int MOD_CNT_W = $clog2(FILL_W + 1);

   // which pointer a wrap reduction writes back
   localparam logic [1:0] SEL_MAIN_WR = 2'b00;
   localparam logic [1:0] SEL_MAIN_RD = 2'b01;
   localparam logic [1:0] SEL_URG_WR  = 2'b10;
   localparam logic [1:0] SEL_URG_RD  = 2'b11;

   function automatic logic [FILL_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [FILL_W-1:0] r;
      if (cap == '0) begin
         r = FILL_W'(1);
      end else if (32'(cap) > RING_DEPTH) begin
         r = FILL_W'(RING_DEPTH);
      end else begin
         r = FILL_W'(cap);
      end
      return r;
   endfunction

   function automatic logic [LVL_W-1:0] lvl_index(input logic [PRIO_W-1:0] prio);
      logic [LVL_EXT_W-1:0] e;
      e = LVL_EXT_W'(prio);
      return e[LVL_W-1:0];
   endfunction

   function automatic logic lvl_ok(input logic [PRIO_W-1:0] prio);
      return 32'(prio) < PRIORITY_LEVELS;
   endfunction

   // ring state
   logic [HANDLE_BITS-1:0] main_mem [RING_DEPTH];
   logic [HANDLE_BITS-1:0] urg_mem  [RING_DEPTH];
   logic [HANDLE_BITS-1:0] main_rd_data_ff;
   logic [HANDLE_BITS-1:0] urg_rd_data_ff;
   logic [PTR_W-1:0]       main_rd_ptr_ff, main_rd_ptr_in;
   logic [PTR_W-1:0]       main_wr_ptr_ff, main_wr_ptr_in;
   logic [PTR_W-1:0]       urg_rd_ptr_ff, urg_rd_ptr_in;
   logic [PTR_W-1:0]       urg_wr_ptr_ff, urg_wr_ptr_in;
   logic [FILL_W-1:0]      main_fill_ff, main_fill_in;
   logic [FILL_W-1:0]      urg_fill_ff, urg_fill_in;

   // statistics
   logic [COUNT_W-1:0] drop_ff, drop_in;
   logic [COUNT_W-1:0] routed_ff, routed_in;
   logic [COUNT_W-1:0] served_ff, served_in;
   logic [COUNT_W-1:0] level_ff [PRIORITY_LEVELS];
   logic [COUNT_W-1:0] level_in [PRIORITY_LEVELS];

   // result stage
   logic                b_valid_ff;
   logic [STATUS_W-1:0] b_status_ff;
   logic                b_deq_ff;
   logic                b_from_urg_ff;
   logic [PRIO_W-1:0]   b_prio_ff;

   // wrap reduction unit
   logic                 mod_busy_ff;
   logic [MOD_CNT_W-1:0] mod_cnt_ff;
   logic [FILL_W-1:0]    mod_x_ff;
   logic [FILL_W-1:0]    mod_r_ff;
   logic [FILL_W-1:0]    mod_d_ff;
   logic [1:0]           mod_sel_ff;
   logic [FILL_W:0]      mod_t;
   logic [FILL_W:0]      mod_r_step;
   logic                 mod_last;
   logic [PTR_W-1:0]     mod_result;

   // execute stage signals
   logic [FILL_W-1:0]      cap_main;
   logic [FILL_W-1:0]      cap_urg;
   logic                   a_fire;
   logic                   b_done;
   logic [OP_W-1:0]        a_op;
   logic                   a_is_enq;
   logic                   a_is_deq;
   logic                   use_urg;
   logic [FILL_W-1:0]      sel_fill;
   logic [FILL_W-1:0]      sel_cap;
   logic [PTR_W-1:0]       sel_ptr;
   logic                   ring_full;
   logic                   ring_empty;
   logic                   enq_ok;
   logic                   enq_drop;
   logic                   deq_ok;
   logic                   moving;
   logic [FILL_W-1:0]      ptr_step;
   logic                   wrap_now;
   logic                   needs_mod;
   logic [PTR_W-1:0]       ptr_next;
   logic                   mod_start;
   logic [1:0]             a_sel;
   logic [STATUS_W-1:0]    a_status;
   logic                   main_we;
   logic                   urg_we;
   logic [HANDLE_BITS-1:0] ring_wdata;
   logic [HANDLE_BITS-1:0] b_handle;
   logic                   b_served_inc;
   logic [FILL_W:0]        total;

   // issue control: one command enters execute when result stage and mod unit are free
   assign cap_main = eff_cap(cfg.main_capacity);
   assign cap_urg  = eff_cap(cfg.urgent_capacity);
   assign b_done   = b_valid_ff && rsp_room;
   assign a_fire   = cmd_valid && !mod_busy_ff && (!b_valid_ff || rsp_room);
   assign cmd_take = a_fire;

   // ring selection and decision
   assign a_op       = cmd_ctrl.op;
   assign a_is_enq   = (a_op == OP_ENQUEUE);
   assign a_is_deq   = (a_op == OP_DEQUEUE);
   assign use_urg    = a_is_enq ? cmd_ctrl.to_urgent
                                : (cfg.use_priority_path && (urg_fill_ff != '0));
   assign sel_fill   = use_urg ? urg_fill_ff : main_fill_ff;
   assign sel_cap    = use_urg ? cap_urg : cap_main;
   assign sel_ptr    = a_is_enq ? (use_urg ? urg_wr_ptr_ff : main_wr_ptr_ff)
                                : (use_urg ? urg_rd_ptr_ff : main_rd_ptr_ff);
   assign ring_full  = (sel_fill >= sel_cap);
   assign ring_empty = (sel_fill == '0);
   assign enq_ok     = a_fire && a_is_enq && !ring_full;
   assign enq_drop   = a_fire && a_is_enq && ring_full;
   assign deq_ok     = a_fire && a_is_deq && !ring_empty;
   assign moving     = enq_ok || deq_ok;
   assign a_sel      = {use_urg, a_is_deq};

   // pointer advance modulo the current capacity
   assign ptr_step  = FILL_W'(sel_ptr) + FILL_W'(1);
   assign wrap_now  = (ptr_step == sel_cap);
   assign needs_mod = (ptr_step > sel_cap);
   assign ptr_next  = wrap_now ? '0 : ptr_step[PTR_W-1:0];
   assign mod_start = moving && needs_mod;

   always_comb begin
      unique case (a_op)
         OP_QUERY:   a_status = ST_SUCCESS;
         OP_NULL:    a_status = ST_INVALID;
         OP_ENQUEUE: a_status = ring_full ? ST_FULL : ST_SUCCESS;
         OP_DEQUEUE: a_status = ring_empty ? ST_EMPTY : ST_SUCCESS;
      endcase
   end

   // restoring remainder, one bit per cycle, for a pointer left past a shrunk capacity
   assign mod_t      = {mod_r_ff, mod_x_ff[FILL_W-1]};
   assign mod_r_step = (mod_t >= {1'b0, mod_d_ff}) ? (mod_t - {1'b0, mod_d_ff}) : mod_t;
   assign mod_last   = mod_busy_ff && (mod_cnt_ff == MOD_CNT_W'(1));
   assign mod_result = mod_r_step[PTR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
         mod_cnt_ff  <= '0;
      end else if (mod_start) begin
         mod_busy_ff <= 1'b1;
         mod_cnt_ff  <= MOD_CNT_W'(FILL_W);
      end else if (mod_busy_ff) begin
         mod_busy_ff <= !mod_last;
         mod_cnt_ff  <= mod_cnt_ff - MOD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mod_start) begin
         mod_x_ff   <= ptr_step;
         mod_r_ff   <= '0;
         mod_d_ff   <= sel_cap;
         mod_sel_ff <= a_sel;
      end else if (mod_busy_ff) begin
         mod_x_ff <= mod_x_ff << 1;
         mod_r_ff <= mod_r_step[FILL_W-1:0];
      end
   end

   // pointer next state
   always_comb begin
      main_rd_ptr_in = main_rd_ptr_ff;
      main_wr_ptr_in = main_wr_ptr_ff;
      urg_rd_ptr_in  = urg_rd_ptr_ff;
      urg_wr_ptr_in  = urg_wr_ptr_ff;
      if (moving && !needs_mod) begin
         unique case (a_sel)
            SEL_MAIN_WR: main_wr_ptr_in = ptr_next;
            SEL_MAIN_RD: main_rd_ptr_in = ptr_next;
            SEL_URG_WR:  urg_wr_ptr_in  = ptr_next;
            SEL_URG_RD:  urg_rd_ptr_in  = ptr_next;
         endcase
      end
      if (mod_last) begin
         unique case (mod_sel_ff)
            SEL_MAIN_WR: main_wr_ptr_in = mod_result;
            SEL_MAIN_RD: main_rd_ptr_in = mod_result;
            SEL_URG_WR:  urg_wr_ptr_in  = mod_result;
            SEL_URG_RD:  urg_rd_ptr_in  = mod_result;
         endcase
      end
   end

   // fills and statistics next state
   always_comb begin
      main_fill_in = main_fill_ff;
      urg_fill_in  = urg_fill_ff;
      if (moving) begin
         if (use_urg) begin
            urg_fill_in = a_is_enq ? (urg_fill_ff + FILL_W'(1)) : (urg_fill_ff - FILL_W'(1));
         end else begin
            main_fill_in = a_is_enq ? (main_fill_ff + FILL_W'(1))
                                    : (main_fill_ff - FILL_W'(1));
         end
      end
      drop_in   = drop_ff + COUNT_W'(enq_drop);
      routed_in = routed_ff + COUNT_W'(a_fire && a_is_enq && cmd_ctrl.to_urgent);
      served_in = served_ff + COUNT_W'(b_done && b_served_inc);
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
         level_in[i] = level_ff[i];
      end
      if (enq_ok && lvl_ok(cmd_ctrl.prio)) begin
         level_in[lvl_index(cmd_ctrl.prio)] = level_ff[lvl_index(cmd_ctrl.prio)] + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_rd_ptr_ff <= '0;
         main_wr_ptr_ff <= '0;
         urg_rd_ptr_ff  <= '0;
         urg_wr_ptr_ff  <= '0;
         main_fill_ff   <= '0;
         urg_fill_ff    <= '0;
         drop_ff        <= '0;
         routed_ff      <= '0;
         served_ff      <= '0;
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         main_rd_ptr_ff <= main_rd_ptr_in;
         main_wr_ptr_ff <= main_wr_ptr_in;
         urg_rd_ptr_ff  <= urg_rd_ptr_in;
         urg_wr_ptr_ff  <= urg_wr_ptr_in;
         main_fill_ff   <= main_fill_in;
         urg_fill_ff    <= urg_fill_in;
         drop_ff        <= drop_in;
         routed_ff      <= routed_in;
         served_ff      <= served_in;
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            level_ff[i] <= level_in[i];
         end
      end
   end

   // ring memories: enqueue writes the handle, dequeue reads the slot and clears it
   assign main_we    = moving && !use_urg;
   assign urg_we     = moving && use_urg;
   assign ring_wdata = a_is_enq ? cmd_handle : '0;

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[sel_ptr] <= ring_wdata;
      end
      if (deq_ok && !use_urg) begin
         main_rd_data_ff <= main_mem[sel_ptr];
      end
   end

   always_ff @(posedge clock) begin
      if (urg_we) begin
         urg_mem[sel_ptr] <= ring_wdata;
      end
      if (deq_ok && use_urg) begin
         urg_rd_data_ff <= urg_mem[sel_ptr];
      end
   end

   // result stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_fire) begin
         b_valid_ff <= 1'b1;
      end else if (b_done) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_status_ff   <= a_status;
         b_deq_ff      <= deq_ok;
         b_from_urg_ff <= deq_ok && use_urg;
         b_prio_ff     <= cmd_ctrl.prio;
      end
   end

   // result build from the state left by this transaction
   assign b_handle     = !b_deq_ff ? '0 : (b_from_urg_ff ? urg_rd_data_ff : main_rd_data_ff);
   assign b_served_inc = b_from_urg_ff && (b_handle != '0);
   assign total        = {1'b0, main_fill_ff} +
                         (cfg.use_priority_path ? {1'b0, urg_fill_ff} : '0);

   always_comb begin
      rsp_stat.status              = b_status_ff;
      rsp_stat.from_urgent         = b_from_urg_ff;
      rsp_stat.total_count         = TOTAL_W'(total);
      rsp_stat.all_empty           = (total == '0);
      rsp_stat.all_full            = (main_fill_ff >= cap_main) &&
                                     (!cfg.use_priority_path || (urg_fill_ff >= cap_urg));
      rsp_stat.dropped_count       = drop_ff;
      rsp_stat.urgent_routed_count = routed_ff;
      rsp_stat.urgent_served_count = served_ff + COUNT_W'(b_served_inc);
      rsp_stat.level_count         = lvl_ok(b_prio_ff) ? level_ff[lvl_index(b_prio_ff)] : '0;
   end

   assign rsp_push   = b_done;
   assign rsp_handle = b_handle;

   `TLPEF_ASSERT_ALWAYS(a_fill_bound, (32'(main_fill_ff) <= RING_DEPTH) && (32'(urg_fill_ff) <= RING_DEPTH), "ring fill above depth")
   `TLPEF_ASSERT_NEXT(a_drop_only_on_enqueue, a_fire && !a_is_enq, drop_ff == $past(drop_ff), "drop counter moved without an enqueue")

endmodule

// ----- hw/rtl/two_level_priority_event_fifo.sv -----
// Two-level priority event fifo: a main ring and an urgent ring of event handles.
// Request channel (push/full): cmd, event_handle, event_priority. A transaction is
//   taken at a clock edge with push high and full low.
// Response channel (empty/pop): one result per request, in request order; the oldest
//   result is on the rsp_ ports while empty is low and leaves on pop with empty low.
// Config port (csr_): write enable, index, data; write only while no request is
//   outstanding. Registers: priority path enable, critical level, main and urgent
//   capacity.
// Path: command queue, execute stage, result stage, then result queue.
// Throughput: one transaction per cycle unless the remainder unit is busy or the
//   result stage is held, set by the single execute stage that owns both rings,
//   their pointers and counters. A pointer left beyond a reduced capacity is wrapped
//   by a bit-serial remainder unit, which holds off later transactions until done.
// Stall: a held-off pop backs up the 2-entry result queue, then the execute stage,
//   then the 2-entry command queue; full rises once that queue is filled.
// Reset (synchronous, active high): registers to defaults, both rings empty, all
//   counters zero; ring contents are undefined and never read before written.
// Depends on tlpef_pkg, tlpef_front, tlpef_queue and tlpef_back.
module two_level_priority_event_fifo import tlpef_pkg::*; #(
   parameter int RING_DEPTH      = RING_DEPTH_DEF,
   parameter int HANDLE_BITS     = HANDLE_BITS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   push,
   output logic                   full,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [HANDLE_BITS-1:0] req_event_handle,
   input  logic [PRIO_W-1:0]      req_event_priority,
   output logic                   empty,
   input  logic                   pop,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_handle_out,
   output logic                   rsp_from_urgent,
   output logic [TOTAL_W-1:0]     rsp_total_count,
   output logic                   rsp_all_empty,
   output logic                   rsp_all_full,
   output logic [COUNT_W-1:0]     rsp_dropped_count,
   output logic [COUNT_W-1:0]     rsp_urgent_routed_count,
   output logic [COUNT_W-1:0]     rsp_urgent_served_count,
   output logic [COUNT_W-1:0]     rsp_level_count
);

   typedef struct packed {
      cmd_ctrl_type           ctrl;
      logic [HANDLE_BITS-1:0] handle;
   } cmd_type;

   typedef struct packed {
      rsp_stat_type           stat;
      logic [HANDLE_BITS-1:0] handle;
   } rsp_type;

   cfg_type      cfg;
   cmd_ctrl_type front_ctrl;
   cmd_type      cmd_wdata;
   cmd_type      cmd_head;
   logic         cmd_empty;
   logic         cmd_take;
   rsp_type      rsp_wdata;
   rsp_type      rsp_head;
   logic         rsp_full;
   logic         rsp_push;
   rsp_stat_type back_stat;
   logic [HANDLE_BITS-1:0] back_handle;

   // configuration and classification
   tlpef_front #(
      .HANDLE_BITS(HANDLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_cmd           (req_cmd),
      .req_event_handle  (req_event_handle),
      .req_event_priority(req_event_priority),
      .cfg               (cfg),
      .ctrl              (front_ctrl)
   );

   // command queue between front and back
   assign cmd_wdata.ctrl   = front_ctrl;
   assign cmd_wdata.handle = req_event_handle;

   tlpef_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .data_type(cmd_type)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .wdata(cmd_wdata),
      .full (full),
      .pop  (cmd_take),
      .rdata(cmd_head),
      .empty(cmd_empty)
   );

   // ring execution
   tlpef_back #(
      .RING_DEPTH     (RING_DEPTH),
      .HANDLE_BITS    (HANDLE_BITS),
      .PRIORITY_LEVELS(PRIORITY_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (!cmd_empty),
      .cmd_ctrl  (cmd_head.ctrl),
      .cmd_handle(cmd_head.handle),
      .cmd_take  (cmd_take),
      .rsp_room  (!rsp_full),
      .rsp_push  (rsp_push),
      .rsp_stat  (back_stat),
      .rsp_handle(back_handle)
   );

   // result queue toward the response port
   assign rsp_wdata.stat   = back_stat;
   assign rsp_wdata.handle = back_handle;

   tlpef_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .data_type(rsp_type)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(rsp_wdata),
      .full (rsp_full),
      .pop  (pop),
      .rdata(rsp_head),
      .empty(empty)
   );

   assign rsp_status              = rsp_head.stat.status;
   assign rsp_handle_out          = rsp_head.handle;
   assign rsp_from_urgent         = rsp_head.stat.from_urgent;
   assign rsp_total_count         = rsp_head.stat.total_count;
   assign rsp_all_empty           = rsp_head.stat.all_empty;
   assign rsp_all_full            = rsp_head.stat.all_full;
   assign rsp_dropped_count       = rsp_head.stat.dropped_count;
   assign rsp_urgent_routed_count = rsp_head.stat.urgent_routed_count;
   assign rsp_urgent_served_count = rsp_head.stat.urgent_served_count;
   assign rsp_level_count         = rsp_head.stat.level_count;

endmodule
